/* rtl/core/modular_exponentiation_assert.svh */
// Assertion macros shared by the modular exponentiation RTL.
// Depends on signals named clk and rst_n in the including module.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MEXP_ASSERT(lbl, prop, msg)
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/mexp_pkg.sv */
// Shared widths, types and constants for the modular exponentiation block.
// No dependencies.
package mexp_pkg;
  localparam int MOD_W = 31;
  localparam int EXP_W = 63;
  localparam int CNT_W = $clog2(MOD_W + 1);

  typedef logic [MOD_W-1:0] residue_t;
  typedef logic [EXP_W-1:0] exponent_t;

  localparam residue_t MODULUS_RESET = MOD_W'(1000000007);
  localparam residue_t RES_ZERO      = '0;
  localparam residue_t RES_ONE       = MOD_W'(1);
  localparam residue_t RES_TWO       = MOD_W'(2);

  localparam logic CMD_POWER   = 1'b0;
  localparam logic CMD_INVERSE = 1'b1;
endpackage

/* rtl/core/mexp_modmul.sv */
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// Depends on mexp_pkg and modular_exponentiation_assert.svh.
`include "modular_exponentiation_assert.svh"
module mexp_modmul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  mexp_pkg::residue_t a_i,   // any value
  input  mexp_pkg::residue_t b_i,   // below m_i
  input  mexp_pkg::residue_t m_i,
  output logic              done_o,
  output mexp_pkg::residue_t p_o
);
  import mexp_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  residue_t         a_r, a_nxt;
  residue_t         b_r, b_nxt;
  residue_t         p_r, p_nxt;

  logic [MOD_W+1:0] sum;
  logic [MOD_W+1:0] m1;
  logic [MOD_W+1:0] m2;
  logic [MOD_W+1:0] red;

  // 2p + bit*b stays below 3m: take off m or 2m
  always_comb begin
    sum = {1'b0, p_r, 1'b0} + (a_r[MOD_W-1] ? {2'b00, b_r} : '0);
    m1  = {2'b00, m_i};
    m2  = {1'b0, m_i, 1'b0};
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(MOD_W);
      a_nxt    = a_i;
      b_nxt    = b_i;
      p_nxt    = '0;
    end else if (busy_r) begin
      p_nxt   = red[MOD_W-1:0];
      a_nxt   = {a_r[MOD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done_o = done_r;
  assign p_o    = p_r;

  `MEXP_ASSERT(a_mul_no_restart, start_i |-> !busy_r, "multiplier restarted while busy")
  `MEXP_ASSERT(a_mul_partial_reduced, busy_r |-> (p_r < m_i), "partial product not reduced")
  `MEXP_ASSERT(a_mul_done_pulse, done_r |=> !done_r, "done held longer than one cycle")
endmodule

/* rtl/core/modular_exponentiation.sv */
// Modular exponentiation by right-to-left square and multiply, bit-serial.
// Trivial items (modulus below 2 or zero exponent) skip to S_FIN; others reduce the base,
// then run one square-and-multiply step per exponent bit up to the top set bit (at most
// 63 bits) on the bit-serial multipliers; a full output register holds the item in S_FIN.
// One item at a time: no new beat is taken until the result is in the output register.
// Reset (rst_n, synchronous, active low): idle, no result held, modulus 1000000007.
`include "modular_exponentiation_assert.svh"
module modular_exponentiation (
  input  logic                      clk,
  input  logic                      rst_n,
  // input beats
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [95:0]               in_tdata,  // [30:0] base, [93:31] exponent, rest zero
  input  logic                      in_tuser,  // [0] command
  // result beats
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata, // [30:0] result, [31] zero
  // modulus register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mexp_pkg::MOD_W-1:0] cfg_data
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0; // wait for an input beat
  localparam logic [2:0] S_LOAD = 3'd1; // start base reduction
  localparam logic [2:0] S_RED  = 3'd2; // wait for reduced base
  localparam logic [2:0] S_STEP = 3'd3; // start multiply and square together
  localparam logic [2:0] S_WAIT = 3'd4; // wait for both products
  localparam logic [2:0] S_FIN  = 3'd5; // hand result to the output register

  logic [2:0] state_r, state_nxt;
  residue_t   mod_r, mod_nxt;
  residue_t   acc_r, acc_nxt;   // running product, result at the end
  residue_t   sq_r, sq_nxt;     // raw base until reduced, then running square
  exponent_t  exp_r, exp_nxt;
  logic       out_valid_r, out_valid_nxt;
  residue_t   out_res_r, out_res_nxt;

  logic       in_beat;
  residue_t   in_base;
  exponent_t  in_exp;
  exponent_t  eff_exp;
  exponent_t  exp_shift;

  logic       mul0_start, mul1_start;
  residue_t   mul0_a, mul0_b;
  logic       mul0_done, mul1_done;
  residue_t   mul0_p, mul1_p;

  assign in_base  = in_tdata[MOD_W-1:0];
  assign in_exp   = in_tdata[MOD_W+EXP_W-1:MOD_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_beat  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Inverse by Fermat: raise to modulus minus two
  assign eff_exp  = (in_tuser == CMD_INVERSE) ?
                    {(EXP_W-MOD_W)'(0), mod_r - RES_TWO} : in_exp;
  assign exp_shift = {1'b0, exp_r[EXP_W-1:1]};

  // Unit 0 reduces the base first (base times one), then forms acc * sq;
  // unit 1 squares alongside it
  assign mul0_start = (state_r == S_LOAD) || (state_r == S_STEP);
  assign mul1_start = (state_r == S_STEP);
  assign mul0_a     = (state_r == S_LOAD) ? sq_r : acc_r;
  assign mul0_b     = (state_r == S_LOAD) ? RES_ONE : sq_r;

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    exp_nxt       = exp_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_valid) begin
      mod_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          sq_nxt  = in_base;
          exp_nxt = eff_exp;
          acc_nxt = RES_ONE;
          if (mod_r < RES_TWO) begin
            // degenerate modulus: everything reduces to zero
            acc_nxt   = RES_ZERO;
            state_nxt = S_FIN;
          end else if (eff_exp == '0) begin
            // zero to the zero gives zero, anything else to the zero gives one
            acc_nxt   = (in_base == RES_ZERO) ? RES_ZERO : RES_ONE;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_nxt = S_RED;
      end
      S_RED: begin
        if (mul0_done) begin
          sq_nxt    = mul0_p;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mul1_done) begin
          if (exp_r[0]) begin
            acc_nxt = mul0_p;
          end
          sq_nxt  = mul1_p;
          exp_nxt = exp_shift;
          // stop once no set bit is left
          state_nxt = (exp_shift == '0) ? S_FIN : S_STEP;
        end
      end
      S_FIN: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    exp_r     <= exp_nxt;
    out_res_r <= out_res_nxt;
  end

  mexp_modmul u_mul0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul0_start),
    .a_i     (mul0_a),
    .b_i     (mul0_b),
    .m_i     (mod_r),
    .done_o  (mul0_done),
    .p_o     (mul0_p)
  );

  mexp_modmul u_mul1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul1_start),
    .a_i     (sq_r),
    .b_i     (sq_r),
    .m_i     (mod_r),
    .done_o  (mul1_done),
    .p_o     (mul1_p)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

  `MEXP_ASSERT(a_res_reduced, out_valid_r |-> (mod_r < RES_TWO || out_res_r < mod_r), "bad result")
  `MEXP_ASSERT(a_units_in_step, (state_r == S_WAIT) |-> (mul0_done == mul1_done), "units apart")
  `MEXP_ASSERT(a_busy_after_beat, in_beat |=> !in_tready, "input taken while busy")
endmodule
